// ===== hdl/vertex_rotate_project_assert.svh =====
// Assertion macros used by the checker file of the vertex rotate and project block.
`ifndef VERTEX_ROTATE_PROJECT_ASSERT_SVH
`define VERTEX_ROTATE_PROJECT_ASSERT_SVH
// Same-cycle implication, sampled on clk and disabled while reset is asserted.
`define VRP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vertex_rotate_project assertion failed");
// Next-cycle implication, sampled on clk and disabled while reset is asserted.
`define VRP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vertex_rotate_project assertion failed");
`endif

// ===== hdl/vrp_pkg.sv =====
// Package of the vertex rotate and project block: widths, register codes and shared types.
package vrp_pkg;

	localparam int COORD_BITS     = 12;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int DIM_BITS       = 12;

	localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
	localparam int FOCAL_W    = 12;
	localparam int OUT_W      = 16;
	localparam int ADDR_W     = 24;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = (2 * DIM_BITS > TRIG_W) ? 2 * DIM_BITS : TRIG_W;

	localparam int NEAR_OFFSET = 500;
	localparam int ROUND_HALF  = 1 << (TRIG_FRAC_BITS - 1);

	// Datapath widths through the three rotations and the projection.
	localparam int X1_W  = COORD_BITS + TRIG_FRAC_BITS;
	localparam int Y1_W  = TRIG_W + COORD_BITS + 1;
	localparam int P2_W  = TRIG_W + ((Y1_W > X1_W) ? Y1_W : X1_W);
	localparam int X2_W  = P2_W + 1 - TRIG_FRAC_BITS;
	localparam int P3_W  = TRIG_W + ((X2_W > Y1_W) ? X2_W : Y1_W);
	localparam int X3_W  = P3_W + 1 - TRIG_FRAC_BITS;
	localparam int DEN_W = X3_W + 1;
	localparam int PF_W  = FOCAL_W + 1 + X3_W;
	localparam int PH_W  = DIM_BITS + DEN_W;
	localparam int NUM_W = ((PF_W > PH_W) ? PF_W : PH_W) + 1;
	localparam int MAG_W = NUM_W - 1;
	localparam int QB    = OUT_W - 1;
	localparam int CMP_W = ((DEN_W + OUT_W > MAG_W) ? DEN_W + OUT_W : MAG_W) + 1;

	localparam logic signed [OUT_W-1:0] SCR_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SCR_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS_X  = CFG_IDX_W'(0),
		REG_SIN_X  = CFG_IDX_W'(1),
		REG_COS_Z  = CFG_IDX_W'(2),
		REG_SIN_Z  = CFG_IDX_W'(3),
		REG_COS_Y  = CFG_IDX_W'(4),
		REG_SIN_Y  = CFG_IDX_W'(5),
		REG_FOCAL  = CFG_IDX_W'(6),
		REG_SCREEN = CFG_IDX_W'(7)
	} cfg_reg_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_x;
		logic signed [TRIG_W-1:0] sin_x;
		logic signed [TRIG_W-1:0] cos_z;
		logic signed [TRIG_W-1:0] sin_z;
		logic signed [TRIG_W-1:0] cos_y;
		logic signed [TRIG_W-1:0] sin_y;
		logic [FOCAL_W-1:0]       focal;
		logic [DIM_BITS-1:0]      width;
		logic [DIM_BITS-1:0]      height;
	} cfg_t;

	typedef struct packed {
		logic signed [X3_W-1:0] x3;
		logic signed [X2_W-1:0] y2;
		logic signed [X3_W-1:0] z3;
	} rot_t;

	typedef struct packed {
		logic behind;
		logic neg_x;
		logic neg_y;
	} div_side_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] screen_x;
		logic signed [OUT_W-1:0] screen_y;
		logic [ADDR_W-1:0]       pixel_address;
		logic                    on_screen;
		logic                    behind_camera;
	} res_t;

endpackage

// ===== hdl/vrp_if.sv =====
// Channel interfaces of the vertex rotate and project block.
interface vrp_vertex_if;
	import vrp_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface vrp_pixel_if;
	import vrp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] screen_x;
	logic signed [OUT_W-1:0] screen_y;
	logic [ADDR_W-1:0]       pixel_address;
	logic                    on_screen;
	logic                    behind_camera;
	modport source (output valid, screen_x, screen_y, pixel_address, on_screen,
		behind_camera, input ready);
	modport sink (input valid, screen_x, screen_y, pixel_address, on_screen,
		behind_camera, output ready);
endinterface

interface vrp_cfg_if;
	import vrp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/vrp_rotate.sv =====
// Five-stage pipeline that rotates a vertex about X, then Z, then Y.
module vrp_rotate (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  vrp_pkg::cfg_t                         cfg,
	input  logic signed [vrp_pkg::COORD_BITS-1:0] px,
	input  logic signed [vrp_pkg::COORD_BITS-1:0] py,
	input  logic signed [vrp_pkg::COORD_BITS-1:0] pz,
	output logic                                  out_valid,
	output vrp_pkg::rot_t                         rot
);
	import vrp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [X1_W-1:0]  x1_s1;
	logic signed [Y1_W-1:0]  y1_s1, z1_s1, z1_s2, z1_s3;
	logic signed [P2_W-1:0]  czx_s2, szy_s2, szx_s2, czy_s2;
	logic signed [X2_W-1:0]  x2_s3, y2_s3, y2_s4, y2_s5;
	logic signed [P3_W-1:0]  cyx_s4, syz_s4, cyz_s4, syx_s4;
	logic signed [X3_W-1:0]  x3_s5, z3_s5;
	logic signed [P2_W:0]    sum_x2, sum_y2;
	logic signed [P3_W:0]    sum_x3, sum_z3;

	// Rounded sums of the Z and Y rotations.
	always_comb begin
		sum_x2 = czx_s2 - szy_s2 + ROUND_HALF;
		sum_y2 = szx_s2 + czy_s2 + ROUND_HALF;
		sum_x3 = cyx_s4 + syz_s4 + ROUND_HALF;
		sum_z3 = cyz_s4 - syx_s4 + ROUND_HALF;
	end

	// Valid bits advance with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Datapath: X rotation unrounded in one stage; for Z and Y, products, then rounded sums.
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1  <= X1_W'(px) <<< TRIG_FRAC_BITS;
			y1_s1  <= cfg.cos_x * py - cfg.sin_x * pz;
			z1_s1  <= cfg.sin_x * py + cfg.cos_x * pz;

			czx_s2 <= cfg.cos_z * x1_s1;
			szy_s2 <= cfg.sin_z * y1_s1;
			szx_s2 <= cfg.sin_z * x1_s1;
			czy_s2 <= cfg.cos_z * y1_s1;
			z1_s2  <= z1_s1;

			x2_s3  <= X2_W'(sum_x2 >>> TRIG_FRAC_BITS);
			y2_s3  <= X2_W'(sum_y2 >>> TRIG_FRAC_BITS);
			z1_s3  <= z1_s2;

			cyx_s4 <= cfg.cos_y * x2_s3;
			syz_s4 <= cfg.sin_y * z1_s3;
			cyz_s4 <= cfg.cos_y * z1_s3;
			syx_s4 <= cfg.sin_y * x2_s3;
			y2_s4  <= y2_s3;

			x3_s5  <= X3_W'(sum_x3 >>> TRIG_FRAC_BITS);
			z3_s5  <= X3_W'(sum_z3 >>> TRIG_FRAC_BITS);
			y2_s5  <= y2_s4;
		end
	end

	assign out_valid = v_s5;
	assign rot.x3    = x3_s5;
	assign rot.y2    = y2_s5;
	assign rot.z3    = z3_s5;

endmodule

// ===== hdl/vrp_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, clamped to 2^QB.
module vrp_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [vrp_pkg::MAG_W-1:0]        mag_x,
	input  logic [vrp_pkg::MAG_W-1:0]        mag_y,
	input  logic [vrp_pkg::DEN_W-2:0]        dmag,
	input  vrp_pkg::div_side_t               side_in,
	output logic                             out_valid,
	output logic [vrp_pkg::OUT_W-1:0]        qx,
	output logic [vrp_pkg::OUT_W-1:0]        qy,
	output vrp_pkg::div_side_t               side_out
);
	import vrp_pkg::*;

	logic                  v_s   [QB+1];
	logic [MAG_W-1:0]      rx_s  [QB+1];
	logic [MAG_W-1:0]      ry_s  [QB+1];
	logic [OUT_W-1:0]      qx_s  [QB+1];
	logic [OUT_W-1:0]      qy_s  [QB+1];
	logic [DEN_W-2:0]      d_s   [QB+1];
	div_side_t             sd_s  [QB+1];
	logic [CMP_W-1:0]      lim;
	logic                  tx_c  [QB];
	logic                  ty_c  [QB];

	// Quotients of 2^QB or more clamp; the first stage detects that case.
	assign lim = CMP_W'(dmag) << QB;

	// A stage subtracts the shifted divisor when the remainder covers it and the quotient has not clamped.
	always_comb begin
		for (int k = 1; k <= QB; k++) begin
			tx_c[k-1] = !qx_s[k-1][QB] &&
				(CMP_W'(rx_s[k-1]) >= (CMP_W'(d_s[k-1]) << (QB - k)));
			ty_c[k-1] = !qy_s[k-1][QB] &&
				(CMP_W'(ry_s[k-1]) >= (CMP_W'(d_s[k-1]) << (QB - k)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k <= QB; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	// Each later stage settles one quotient bit, from the top bit down.
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0] <= mag_x;
			ry_s[0] <= mag_y;
			qx_s[0] <= (CMP_W'(mag_x) >= lim) ? OUT_W'(1) << QB : '0;
			qy_s[0] <= (CMP_W'(mag_y) >= lim) ? OUT_W'(1) << QB : '0;
			d_s[0]  <= dmag;
			sd_s[0] <= side_in;
			for (int k = 1; k <= QB; k++) begin
				d_s[k]  <= d_s[k-1];
				sd_s[k] <= sd_s[k-1];
				rx_s[k] <= tx_c[k-1] ?
					rx_s[k-1] - MAG_W'(CMP_W'(d_s[k-1]) << (QB - k)) : rx_s[k-1];
				ry_s[k] <= ty_c[k-1] ?
					ry_s[k-1] - MAG_W'(CMP_W'(d_s[k-1]) << (QB - k)) : ry_s[k-1];
				qx_s[k] <= qx_s[k-1] | (tx_c[k-1] ? OUT_W'(1) << (QB - k) : '0);
				qy_s[k] <= qy_s[k-1] | (ty_c[k-1] ? OUT_W'(1) << (QB - k) : '0);
			end
		end
	end

	assign out_valid = v_s[QB];
	assign qx        = qx_s[QB];
	assign qy        = qy_s[QB];
	assign side_out  = sd_s[QB];

endmodule

// ===== hdl/vrp_project.sv =====
// Perspective projection pipeline: denominator, numerators, divide, saturate and address.
module vrp_project (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  vrp_pkg::cfg_t cfg,
	input  vrp_pkg::rot_t rot,
	output logic          out_valid,
	output vrp_pkg::res_t res
);
	import vrp_pkg::*;

	logic v_s6, v_s7, v_s8, v_s9, v_s26, v_s27;

	logic signed [DEN_W-1:0] den_s6, den_s7, den_s8;
	logic signed [PF_W-1:0]  fx_s6, fy_s6, fx_s7, fy_s7;
	logic signed [PH_W-1:0]  hx_s7, hy_s7;
	logic signed [NUM_W-1:0] nx_s8, ny_s8;
	logic                    xn_s6, yn_s6, xn_s7, yn_s7, xn_s8, yn_s8, xn_s9, yn_s9;
	logic                    bh_s7, bh_s8, bh_s9;
	logic                    negx_s9, negy_s9;
	logic [MAG_W-1:0]        magx_s9, magy_s9;
	logic [DEN_W-2:0]        dmag_s9;

	logic                    dv;
	logic [OUT_W-1:0]        qx, qy;
	div_side_t               side_in, side_out;

	logic signed [OUT_W-1:0] sx_c, sy_c;
	logic signed [OUT_W-1:0] sx_s26, sy_s26, sx_s27, sy_s27;
	logic                    on_c, on_s26, on_s27, bh_s26, bh_s27;
	logic [ADDR_W-1:0]       addr_s27;
	logic [OUT_W+DIM_BITS-1:0] row_c;

	// Lane sign is the rotated coordinate's when behind the camera, else the numerator's.
	assign side_in.behind = bh_s9;
	assign side_in.neg_x  = bh_s9 ? xn_s9 : negx_s9;
	assign side_in.neg_y  = bh_s9 ? yn_s9 : negy_s9;

	vrp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s9),
		.mag_x    (magx_s9),
		.mag_y    (magy_s9),
		.dmag     (dmag_s9),
		.side_in  (side_in),
		.out_valid(dv),
		.qx       (qx),
		.qy       (qy),
		.side_out (side_out)
	);

	// Sign and saturate the quotient magnitudes, then test the screen bounds.
	always_comb begin
		if (side_out.behind) begin
			sx_c = side_out.neg_x ? SCR_MIN : SCR_MAX;
			sy_c = side_out.neg_y ? SCR_MIN : SCR_MAX;
		end else begin
			if (side_out.neg_x) begin
				sx_c = OUT_W'(~qx + 1'b1);
			end else begin
				sx_c = qx[QB] ? SCR_MAX : qx;
			end
			if (side_out.neg_y) begin
				sy_c = OUT_W'(~qy + 1'b1);
			end else begin
				sy_c = qy[QB] ? SCR_MAX : qy;
			end
		end
		on_c = !side_out.behind && !sx_c[OUT_W-1] && !sy_c[OUT_W-1] &&
			($unsigned(sx_c) < OUT_W'(cfg.width)) &&
			($unsigned(sy_c) < OUT_W'(cfg.height));
		row_c = $unsigned(sy_s26) * cfg.width;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s26 <= 1'b0;
			v_s27 <= 1'b0;
		end else if (en) begin
			v_s6  <= in_valid;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s26 <= dv;
			v_s27 <= v_s26;
		end
	end

	// Datapath stages around the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= ((DEN_W'(cfg.focal) + DEN_W'(NEAR_OFFSET)) << TRIG_FRAC_BITS) +
				DEN_W'(rot.z3);
			fx_s6  <= $signed({1'b0, cfg.focal}) * rot.x3;
			fy_s6  <= $signed({1'b0, cfg.focal}) * rot.y2;
			xn_s6  <= rot.x3[X3_W-1];
			yn_s6  <= rot.y2[X2_W-1];

			hx_s7  <= $signed({1'b0, cfg.width[DIM_BITS-1:1]}) * den_s6;
			hy_s7  <= $signed({1'b0, cfg.height[DIM_BITS-1:1]}) * den_s6;
			fx_s7  <= fx_s6;
			fy_s7  <= fy_s6;
			den_s7 <= den_s6;
			bh_s7  <= den_s6[DEN_W-1] || (den_s6 == '0);
			xn_s7  <= xn_s6;
			yn_s7  <= yn_s6;

			nx_s8  <= NUM_W'(fx_s7) + NUM_W'(hx_s7);
			ny_s8  <= NUM_W'(fy_s7) + NUM_W'(hy_s7);
			den_s8 <= den_s7;
			bh_s8  <= bh_s7;
			xn_s8  <= xn_s7;
			yn_s8  <= yn_s7;

			negx_s9 <= nx_s8[NUM_W-1];
			negy_s9 <= ny_s8[NUM_W-1];
			magx_s9 <= nx_s8[NUM_W-1] ? MAG_W'(-nx_s8) : MAG_W'(nx_s8);
			magy_s9 <= ny_s8[NUM_W-1] ? MAG_W'(-ny_s8) : MAG_W'(ny_s8);
			dmag_s9 <= den_s8[DEN_W-2:0];
			bh_s9   <= bh_s8;
			xn_s9   <= xn_s8;
			yn_s9   <= yn_s8;

			sx_s26 <= sx_c;
			sy_s26 <= sy_c;
			on_s26 <= on_c;
			bh_s26 <= side_out.behind;

			sx_s27   <= sx_s26;
			sy_s27   <= sy_s26;
			on_s27   <= on_s26;
			bh_s27   <= bh_s26;
			addr_s27 <= on_s26 ? ADDR_W'(row_c + (OUT_W+DIM_BITS)'($unsigned(sx_s26))) : '0;
		end
	end

	assign out_valid         = v_s27;
	assign res.screen_x      = sx_s27;
	assign res.screen_y      = sy_s27;
	assign res.pixel_address = addr_s27;
	assign res.on_screen     = on_s27;
	assign res.behind_camera = bh_s27;

endmodule

// ===== hdl/vertex_rotate_project.sv =====
// Accepts one vertex per cycle while no finished pixel waits for ready; the 16-stage
// divider checks the range, then settles one quotient bit per stage.
// The whole pipeline holds while a finished pixel waits for ready, and nothing is lost.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the configuration
// registers with unit cosines, zero sines, focal length 256 and a 640 x 480 screen.
module vertex_rotate_project (
	input  logic        clk,
	input  logic        arst_n,
	vrp_vertex_if.sink  vertex,
	vrp_pixel_if.source pixel,
	vrp_cfg_if.sink     cfg
);
	import vrp_pkg::*;

	cfg_t  cfg_q;
	logic  en;
	logic  rot_valid;
	rot_t  rot;
	logic  res_valid;
	res_t  res;

	// The pipeline moves whenever its output register is empty or being drained.
	assign en           = !res_valid || pixel.ready;
	assign vertex.ready = en;
	assign cfg.ready    = 1'b1;

	// Configuration register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_x  <= TRIG_W'(1) << TRIG_FRAC_BITS;
			cfg_q.sin_x  <= '0;
			cfg_q.cos_z  <= TRIG_W'(1) << TRIG_FRAC_BITS;
			cfg_q.sin_z  <= '0;
			cfg_q.cos_y  <= TRIG_W'(1) << TRIG_FRAC_BITS;
			cfg_q.sin_y  <= '0;
			cfg_q.focal  <= FOCAL_W'(256);
			cfg_q.width  <= DIM_BITS'(640);
			cfg_q.height <= DIM_BITS'(480);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_COS_X:  cfg_q.cos_x <= cfg.data[TRIG_W-1:0];
				REG_SIN_X:  cfg_q.sin_x <= cfg.data[TRIG_W-1:0];
				REG_COS_Z:  cfg_q.cos_z <= cfg.data[TRIG_W-1:0];
				REG_SIN_Z:  cfg_q.sin_z <= cfg.data[TRIG_W-1:0];
				REG_COS_Y:  cfg_q.cos_y <= cfg.data[TRIG_W-1:0];
				REG_SIN_Y:  cfg_q.sin_y <= cfg.data[TRIG_W-1:0];
				REG_FOCAL:  cfg_q.focal <= cfg.data[FOCAL_W-1:0];
				REG_SCREEN: begin
					cfg_q.width  <= cfg.data[2*DIM_BITS-1:DIM_BITS];
					cfg_q.height <= cfg.data[DIM_BITS-1:0];
				end
				default: ;
			endcase
		end
	end

	vrp_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vertex.valid),
		.cfg      (cfg_q),
		.px       (vertex.point_x),
		.py       (vertex.point_y),
		.pz       (vertex.point_z),
		.out_valid(rot_valid),
		.rot      (rot)
	);

	vrp_project u_project (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (rot_valid),
		.cfg      (cfg_q),
		.rot      (rot),
		.out_valid(res_valid),
		.res      (res)
	);

	assign pixel.valid         = res_valid;
	assign pixel.screen_x      = res.screen_x;
	assign pixel.screen_y      = res.screen_y;
	assign pixel.pixel_address = res.pixel_address;
	assign pixel.on_screen     = res.on_screen;
	assign pixel.behind_camera = res.behind_camera;

endmodule

// ===== hdl/vrp_checker.sv =====
// Port-level checker of the vertex rotate and project block and its bind.
`include "vertex_rotate_project_assert.svh"
module vrp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [vrp_pkg::OUT_W-1:0] screen_x,
	input logic signed [vrp_pkg::OUT_W-1:0] screen_y,
	input logic [vrp_pkg::ADDR_W-1:0]       pixel_address,
	input logic                             on_screen,
	input logic                             behind_camera
);
	import vrp_pkg::*;

	// A stalled pixel transaction keeps its coordinates and address.
	`VRP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(screen_x) && $stable(screen_y) && $stable(pixel_address))
	// A waiting pixel blocks new vertices.
	`VRP_ASSERT_NOW(a_in_stall, out_valid && !out_ready, !in_ready)
	// Off-screen pixels carry a zero address.
	`VRP_ASSERT_NOW(a_addr_zero, out_valid && !on_screen, pixel_address == '0)
	// A point behind the camera is never on screen and its coordinates saturate.
	`VRP_ASSERT_NOW(a_behind, out_valid && behind_camera, !on_screen && (screen_x == SCR_MAX || screen_x == SCR_MIN) && (screen_y == SCR_MAX || screen_y == SCR_MIN))

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (vertex.ready),
	.out_valid    (pixel.valid),
	.out_ready    (pixel.ready),
	.screen_x     (pixel.screen_x),
	.screen_y     (pixel.screen_y),
	.pixel_address(pixel.pixel_address),
	.on_screen    (pixel.on_screen),
	.behind_camera(pixel.behind_camera)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the vertex rotate and project block, with its scoreboard.
`timescale 1ns / 100ps

module tb_top;
	import vrp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 34;
	localparam int DRAIN_WAIT  = 40;
	localparam int HOLD_CYCLES = 300;
	// Index past the last register; the block is expected to ignore it.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = CFG_IDX_W'(8);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = CFG_IDX_W'(15);

	// Scoreboard: projects each accepted vertex and checks pixels in order.
	class vertex_projection_board;
		logic signed [TRIG_W-1:0] trig_val [6];
		logic [FOCAL_W-1:0]       focal;
		logic [DIM_BITS-1:0]      width;
		logic [DIM_BITS-1:0]      height;
		res_t                     pending_pixels [$];
		int                       mismatches;

		function new();
			trig_val = '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0};
			focal = 12'd256;
			width = 12'd640;
			height = 12'd480;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx <= REG_SIN_Y)
				trig_val[idx] = value[TRIG_W-1:0];
			else if (idx == REG_FOCAL)
				focal = value[FOCAL_W-1:0];
			else if (idx == REG_SCREEN) begin
				width = value[2*DIM_BITS-1:DIM_BITS];
				height = value[DIM_BITS-1:0];
			end
		endfunction

		// Round a value with twice the fraction bits back to one set, ties upward.
		function longint round_frac(longint p);
			return (p + ROUND_HALF) >>> TRIG_FRAC_BITS;
		endfunction

		function longint clamp16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		function void note_vertex(logic signed [COORD_BITS-1:0] px,
			logic signed [COORD_BITS-1:0] py, logic signed [COORD_BITS-1:0] pz);
			longint cx, sx, cz, sz, cy, sy, x1, y1, z1, x2, y2, x3, z3, den, nx, ny;
			longint col, row, half_w, half_h;
			res_t r;
			cx = trig_val[REG_COS_X];
			sx = trig_val[REG_SIN_X];
			cz = trig_val[REG_COS_Z];
			sz = trig_val[REG_SIN_Z];
			cy = trig_val[REG_COS_Y];
			sy = trig_val[REG_SIN_Y];
			// Rotate about X exactly, then about Z and Y with rounding.
			x1 = longint'(px) <<< TRIG_FRAC_BITS;
			y1 = cx * py - sx * pz;
			z1 = sx * py + cx * pz;
			x2 = round_frac(cz * x1 - sz * y1);
			y2 = round_frac(sz * x1 + cz * y1);
			x3 = round_frac(cy * x2 + sy * z1);
			z3 = round_frac(cy * z1 - sy * x2);
			den = ((longint'(focal) + NEAR_OFFSET) <<< TRIG_FRAC_BITS) + z3;
			r = '0;
			if (den <= 0) begin
				r.behind_camera = 1'b1;
				r.screen_x = (x3 < 0) ? SCR_MIN : SCR_MAX;
				r.screen_y = (y2 < 0) ? SCR_MIN : SCR_MAX;
			end else begin
				half_w = longint'(width) >> 1;
				half_h = longint'(height) >> 1;
				nx = longint'(focal) * x3 + half_w * den;
				ny = longint'(focal) * y2 + half_h * den;
				col = clamp16(nx / den);
				row = clamp16(ny / den);
				r.screen_x = col[OUT_W-1:0];
				r.screen_y = row[OUT_W-1:0];
				if (col >= 0 && col < width && row >= 0 && row < height) begin
					r.on_screen = 1'b1;
					r.pixel_address = ADDR_W'(col + row * longint'(width));
				end
			end
			pending_pixels = {pending_pixels, r};
		endfunction

		function void check_pixel(res_t got);
			res_t want;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pixel transaction with none expected: %p", got);
				return;
			end
			want = pending_pixels.pop_front();
			if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y
				|| got.pixel_address !== want.pixel_address
				|| got.on_screen !== want.on_screen
				|| got.behind_camera !== want.behind_camera) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pixel mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles = 0;
	bit   hold_request;
	bit   hold_taken;
	int   hold_left = 0;
	bit   steady;

	vrp_vertex_if vertex ();
	vrp_pixel_if  pixel ();
	vrp_cfg_if    cfg ();

	vertex_projection_board board;

	vertex_rotate_project dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vertex),
		.pixel  (pixel),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stalls, a steady stretch, and one requested long hold-off.
	always @(posedge clk) begin
		if (!arst_n)
			pixel.ready <= 1'b0;
		else if (hold_request && !hold_taken) begin
			pixel.ready <= 1'b0;
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
		end else if (hold_left > 0) begin
			pixel.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (steady)
			pixel.ready <= 1'b1;
		else
			pixel.ready <= ($urandom_range(99) >= IDLE_PCT);
	end

	// Monitors of the three channels.
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				board.write_reg(cfg.index, cfg.data);
			if (vertex.valid && vertex.ready)
				board.note_vertex(vertex.point_x, vertex.point_y, vertex.point_z);
			if (pixel.valid && pixel.ready) begin
				got.screen_x = pixel.screen_x;
				got.screen_y = pixel.screen_y;
				got.pixel_address = pixel.pixel_address;
				got.on_screen = pixel.on_screen;
				got.behind_camera = pixel.behind_camera;
				board.check_pixel(got);
			end
		end
	end

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Trig values sit in the low bits; upper bits of the data word carry noise.
	task automatic write_trig(cfg_reg_t idx, logic signed [TRIG_W-1:0] value);
		write_cfg(idx, {(CFG_DATA_W-TRIG_W)'($urandom), value});
	endtask

	task automatic load_cfg(logic signed [TRIG_W-1:0] cx, logic signed [TRIG_W-1:0] sx,
		logic signed [TRIG_W-1:0] cz, logic signed [TRIG_W-1:0] sz,
		logic signed [TRIG_W-1:0] cy, logic signed [TRIG_W-1:0] sy,
		logic [FOCAL_W-1:0] fl, logic [2*DIM_BITS-1:0] scr);
		write_trig(REG_COS_X, cx);
		write_trig(REG_SIN_X, sx);
		write_trig(REG_COS_Z, cz);
		write_trig(REG_SIN_Z, sz);
		write_trig(REG_COS_Y, cy);
		write_trig(REG_SIN_Y, sy);
		write_cfg(REG_FOCAL, {12'($urandom), fl});
		write_cfg(REG_SCREEN, scr);
	endtask

	task automatic send_vertex(logic signed [COORD_BITS-1:0] px,
		logic signed [COORD_BITS-1:0] py, logic signed [COORD_BITS-1:0] pz);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			vertex.valid <= 1'b0;
			@(posedge clk);
		end
		vertex.valid <= 1'b1;
		vertex.point_x <= px;
		vertex.point_y <= py;
		vertex.point_z <= pz;
		do @(posedge clk); while (!vertex.ready);
	endtask

	// Stop sending, let the monitor note the last vertex, then wait for every pixel.
	task automatic drain();
		vertex.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [TRIG_W-1:0] rand_trig();
		if ($urandom_range(9) == 0)
			return TRIG_W'($urandom);
		return TRIG_W'($signed($urandom_range(32768)) - 16384);
	endfunction

	function automatic logic [2*DIM_BITS-1:0] rand_screen();
		if ($urandom_range(3) == 0)
			return 24'($urandom);
		return {12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1))};
	endfunction

	task automatic send_random();
		logic signed [COORD_BITS-1:0] c [3];
		foreach (c[i])
			c[i] = ($urandom_range(1) == 0) ? COORD_BITS'($urandom)
				: COORD_BITS'($signed($urandom_range(600)) - 300);
		send_vertex(c[0], c[1], c[2]);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		steady = 1'b0;
		vertex.valid = 1'b0;
		vertex.point_x = '0;
		vertex.point_y = '0;
		vertex.point_z = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed vertices at the reset configuration: extremes, the origin,
		// a zero denominator and points behind the camera.
		send_vertex(12'sd0, 12'sd0, 12'sd0);
		send_vertex(12'sd2047, 12'sd2047, 12'sd2047);
		send_vertex(-12'sd2048, -12'sd2048, 12'sd2047);
		send_vertex(12'sd2047, -12'sd2048, 12'sd0);
		send_vertex(-12'sd2048, 12'sd2047, -12'sd2048);
		send_vertex(12'sd5, -12'sd7, -12'sd756);
		send_vertex(-12'sd5, 12'sd7, -12'sd757);
		send_vertex(12'sd319, 12'sd239, 12'sd0);
		send_vertex(-12'sd320, -12'sd240, 12'sd0);
		send_vertex(12'sd320, 12'sd240, 12'sd0);
		drain();

		// Extreme settings: trig values past unity, a focal length of one,
		// an empty screen, and writes to unused indexes.
		load_cfg(16'sh7fff, -16'sh8000, -16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384,
			12'd1, 24'd0);
		write_cfg(REG_UNUSED_A, 24'hffffff);
		write_cfg(REG_UNUSED_B, 24'h000000);
		send_vertex(12'sd2047, 12'sd2047, 12'sd2047);
		send_vertex(-12'sd2048, -12'sd2048, -12'sd2048);
		send_vertex(12'sd1, -12'sd1, 12'sd0);
		drain();
		load_cfg(-16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd16384,
			12'd4095, 24'hffffff);
		send_vertex(12'sd2047, -12'sd2048, 12'sd2047);
		send_vertex(-12'sd2048, 12'sd2047, -12'sd2048);
		send_vertex(12'sd0, 12'sd0, 12'sd0);
		send_vertex(12'sd100, 12'sd100, -12'sd2048);
		drain();

		// Random phases, each under its own random configuration.
		for (int phase = 0; phase < 8; phase++) begin
			load_cfg(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
				rand_trig(), (phase == 0) ? 12'd1 : 12'($urandom_range(4095, 1)),
				rand_screen());
			steady = (phase == 2);
			for (int n = 0; n < 55; n++) begin
				if (phase == 4 && n == 10)
					hold_request = 1'b1;
				if (phase == 5 && n == 25)
					drain();
				send_random();
			end
			drain();
		end
		steady = 1'b0;

		// Let the pipeline settle before the verdict.
		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.mismatches == 0 && board.pending_pixels.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
